FILE: src/bht_pkg.sv
// ----------------------------------------------------------------------------
// bht_pkg
// Shared types and codes of the bucketed hash table: item payloads, result
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bht_pkg;

	// command field of a request item
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	// status field of a result item
	localparam logic [1:0] RSP_MATCH    = 2'd0;
	localparam logic [1:0] RSP_NO_MATCH = 2'd1;
	localparam logic [1:0] RSP_INSERTED = 2'd2;
	localparam logic [1:0] RSP_ROW_FULL = 2'd3;

	typedef struct packed {
		logic        command;
		logic [63:0] key;
		logic [7:0]  first_length;
		logic [7:0]  second_length;
		logic [31:0] first_hash;
		logic [31:0] second_hash;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] entry_id;
		logic [7:0]  out_first_length;
		logic [7:0]  out_second_length;
		logic [31:0] out_first_hash;
		logic [31:0] out_second_hash;
		logic        last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FILL,
		S_DECIDE,
		S_READ,
		S_CHECK,
		S_FINISH
	} state_t;

	// which result the output register loads
	typedef enum logic [2:0] {
		PUSH_INSERT,
		PUSH_FULL,
		PUSH_MORE,
		PUSH_LAST,
		PUSH_NOMATCH
	} push_sel_t;

	typedef struct packed {
		logic      load;
		logic      clr_step;
		logic      ins_commit;
		logic      idx_inc;
		logic      pend_load;
		logic      pend_clr;
		logic      push;
		push_sel_t push_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
		logic is_insert;
		logic row_full;
		logic fill_zero;
		logic scan_end;
		logic match;
		logic pend_valid;
	} ctrl_sts_t;

endpackage

FILE: src/bht_ctrl.sv
// ----------------------------------------------------------------------------
// bht_ctrl
// Sequencer of the hash table: clearing pass, fill read, insert decision and
// the slot-by-slot lookup scan.
// ----------------------------------------------------------------------------
module bht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  bht_pkg::ctrl_sts_t sts,
	output bht_pkg::ctrl_cmd_t cmd
);
	import bht_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	// hold the scan while an earlier match still waits for the output register
	assign stall     = sts.match && sts.pend_valid && !sts.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_FILL;
			end
			S_FILL: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.is_insert) begin
					if (sts.out_free) state_d = S_IDLE;
				end else if (sts.fill_zero) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!stall) state_d = sts.scan_end ? S_FINISH : S_READ;
			end
			S_FINISH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd.load       = 1'b0;
		cmd.clr_step   = 1'b0;
		cmd.ins_commit = 1'b0;
		cmd.idx_inc    = 1'b0;
		cmd.pend_load  = 1'b0;
		cmd.pend_clr   = 1'b0;
		cmd.push       = 1'b0;
		cmd.push_sel   = PUSH_NOMATCH;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			S_IDLE: begin
				cmd.load = req_valid;
			end
			S_DECIDE: begin
				if (sts.is_insert && sts.out_free) begin
					cmd.push       = 1'b1;
					cmd.push_sel   = sts.row_full ? PUSH_FULL : PUSH_INSERT;
					cmd.ins_commit = !sts.row_full;
				end
			end
			S_CHECK: begin
				if (!stall) begin
					cmd.idx_inc = 1'b1;
					if (sts.match) begin
						cmd.pend_load = 1'b1;
						cmd.push      = sts.pend_valid;
						cmd.push_sel  = PUSH_MORE;
					end
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.push     = 1'b1;
					cmd.push_sel = sts.pend_valid ? PUSH_LAST : PUSH_NOMATCH;
					cmd.pend_clr = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && stall) |=> (state_q == S_CHECK))
		else $error("scan advanced while a match was held back");

endmodule

FILE: src/bht_dpath.sv
// ----------------------------------------------------------------------------
// bht_dpath
// Datapath of the hash table: item registers, row fill memory with clearing
// counter, slot memory, held match and the output register.
// ----------------------------------------------------------------------------
module bht_dpath #(
	parameter int ROW_BITS      = 10,
	parameter int SLOTS_PER_ROW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bht_pkg::ctrl_cmd_t cmd,
	output bht_pkg::ctrl_sts_t sts,
	input  bht_pkg::req_t      req,
	input  logic               cfg_wen,
	input  logic [31:0]        cfg_wdata,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output bht_pkg::rsp_t      rsp
);
	import bht_pkg::*;

	localparam int ROWS    = 1 << ROW_BITS;
	localparam int SLOTS   = ROWS * SLOTS_PER_ROW;
	localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FILL_W  = $clog2(SLOTS_PER_ROW + 1);
	localparam int TAG_W   = 64 - ROW_BITS;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [7:0]       len1;
		logic [7:0]       len2;
		logic [31:0]      hash1;
		logic [31:0]      hash2;
		logic [31:0]      ident;
	} slot_t;

	slot_t             slot_mem [SLOTS];
	logic [FILL_W-1:0] fill_mem [ROWS];

	logic              cmd_q;
	logic [ROW_BITS-1:0] row_q;
	logic [TAG_W-1:0]  tag_q;
	logic [7:0]        len1_q;
	logic [7:0]        len2_q;
	logic [31:0]       hash1_q;
	logic [31:0]       hash2_q;
	logic [FILL_W-1:0] idx_q;
	logic [FILL_W-1:0] fill_rd_q;
	slot_t             slot_rd_q;
	slot_t             pend_q;
	logic              pend_valid_q;
	logic [ROW_BITS-1:0] clr_q;
	logic [31:0]       id_base_q;
	logic [31:0]       ins_cnt_q;
	logic              out_valid_q;
	rsp_t              rsp_q;

	logic [SLOT_AW-1:0] row_base;
	logic [SLOT_AW-1:0] slot_wr_addr;
	logic [SLOT_AW-1:0] slot_rd_addr;
	logic [31:0]        new_id;
	logic               out_free;
	slot_t              slot_wr;
	rsp_t               rsp_d;

	assign row_base     = SLOT_AW'(row_q) * SLOT_AW'(SLOTS_PER_ROW);
	assign slot_wr_addr = row_base + SLOT_AW'(fill_rd_q);
	assign slot_rd_addr = row_base + SLOT_AW'(idx_q);
	assign new_id       = id_base_q + ins_cnt_q + 32'd1;
	assign out_free     = !out_valid_q || rsp_ready;

	assign slot_wr = '{tag: tag_q, len1: len1_q, len2: len2_q,
		hash1: hash1_q, hash2: hash2_q, ident: new_id};

	// item registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= req.command;
			row_q   <= req.key[63 -: ROW_BITS];
			tag_q   <= req.key[TAG_W-1:0];
			len1_q  <= req.first_length;
			len2_q  <= req.second_length;
			hash1_q <= req.first_hash;
			hash2_q <= req.second_hash;
		end
	end

	// row fill memory
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			fill_mem[clr_q] <= '0;
		end else if (cmd.ins_commit) begin
			fill_mem[row_q] <= FILL_W'(fill_rd_q + 1'b1);
		end
		fill_rd_q <= fill_mem[row_q];
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (cmd.ins_commit) begin
			slot_mem[slot_wr_addr] <= slot_wr;
		end
		slot_rd_q <= slot_mem[slot_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_load) begin
			pend_q <= slot_rd_q;
		end
		if (cmd.push) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			clr_q        <= '0;
			id_base_q    <= '0;
			ins_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= FILL_W'(idx_q + 1'b1);
			end
			if (cmd.pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.pend_clr) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.clr_step) begin
				clr_q <= ROW_BITS'(clr_q + 1'b1);
			end
			if (cfg_wen) begin
				id_base_q <= cfg_wdata;
			end
			if (cmd.ins_commit) begin
				ins_cnt_q <= ins_cnt_q + 32'd1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		rsp_d = '0;
		unique case (cmd.push_sel)
			PUSH_INSERT: begin
				rsp_d.status   = RSP_INSERTED;
				rsp_d.entry_id = new_id;
				rsp_d.last     = 1'b1;
			end
			PUSH_FULL: begin
				rsp_d.status = RSP_ROW_FULL;
				rsp_d.last   = 1'b1;
			end
			PUSH_MORE, PUSH_LAST: begin
				rsp_d.status            = RSP_MATCH;
				rsp_d.entry_id          = pend_q.ident;
				rsp_d.out_first_length  = pend_q.len1;
				rsp_d.out_second_length = pend_q.len2;
				rsp_d.out_first_hash    = pend_q.hash1;
				rsp_d.out_second_hash   = pend_q.hash2;
				rsp_d.last              = (cmd.push_sel == PUSH_LAST);
			end
			PUSH_NOMATCH: begin
				rsp_d.status = RSP_NO_MATCH;
				rsp_d.last   = 1'b1;
			end
			default: begin
				rsp_d.status = RSP_NO_MATCH;
				rsp_d.last   = 1'b1;
			end
		endcase
	end

	assign sts.clr_last   = &clr_q;
	assign sts.out_free   = out_free;
	assign sts.is_insert  = (cmd_q == CMD_INSERT);
	assign sts.row_full   = (fill_rd_q >= FILL_W'(SLOTS_PER_ROW));
	assign sts.fill_zero  = (fill_rd_q == '0);
	assign sts.scan_end   = (FILL_W'(idx_q + 1'b1) == fill_rd_q);
	assign sts.match      = (slot_rd_q.tag == tag_q);
	assign sts.pend_valid = pend_valid_q;

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> out_free)
		else $error("result pushed over an untaken result");

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_commit |-> (fill_rd_q < FILL_W'(SLOTS_PER_ROW)))
		else $error("slot written into a full row");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && cmd.push_sel == PUSH_LAST) |=> !pend_valid_q)
		else $error("held match survived the final result");

endmodule

FILE: src/bucketed_hash_table_unit.sv
// ----------------------------------------------------------------------------
// bucketed_hash_table_unit
// Bucketed hash table with per-row slot lists, insert and lookup commands.
// ----------------------------------------------------------------------------
// The table holds 2^ROW_BITS rows of SLOTS_PER_ROW slots. The top ROW_BITS bits
// of a 64-bit key pick the row; the low bits are stored as the slot tag. After
// reset the block runs a clearing pass over the row fill memory, one row a
// cycle; req_ready stays low until it is done, while id_base writes are taken
// as usual. One item is worked on at a time. An insert passes from acceptance
// through the item register, the fill memory read and the decision with slot
// and fill write to its result. In a lookup the slot memory has one registered
// read port, so each used slot of the row is first read and then compared.
// Both commands wait while the result output is stalled. A lookup gives every
// matching slot in insertion order, last set on the final one, or a single
// no-match item. Identifiers are id_base plus the count of successful inserts
// up to and including the one that gets it, modulo 2^32.
module bucketed_hash_table_unit #(
	parameter int ROW_BITS      = 10,
	parameter int SLOTS_PER_ROW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bht_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bht_pkg::rsp_t rsp,
	input  logic          cfg_wen,
	input  logic [31:0]   cfg_wdata
);
	import bht_pkg::*;

	// command and status bundles between sequencer and datapath
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// sequencer: clear pass, insert decision, slot scan
	bht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage, compare and output register
	bht_dpath #(
		.ROW_BITS      (ROW_BITS),
		.SLOTS_PER_ROW (SLOTS_PER_ROW)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
